// ===== rtl/huf_pkg.sv =====
// Shared types and constants for the code-tree decoder.
// No dependencies; imported by every module of the block.
package huf_pkg;

  // Default sizes of the node store and of the longest code.
  localparam int MAX_NODES_DEF    = 512;
  localparam int MAX_CODE_LEN_DEF = 32;

  // Widths of the fixed payload fields.
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_LOAD   = 2'd1;
  localparam logic [1:0] FUNC_DECODE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [1:0]        func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;     // first code bit at the top position
    logic [LEN_W-1:0]  eff_len;  // clipped code length
    logic              bit_req;
    logic              eos;
  } op_t;

endpackage

// ===== rtl/huf_front.sv =====
// Front part of the code-tree decoder: takes input items and classifies them.
// Clips the code length and left-aligns the code of load items. Depends on huf_pkg.
module huf_front #(
  parameter int MAX_CODE_LEN = huf_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [huf_pkg::SYM_W-1:0] in_symbol,
  input  logic [huf_pkg::CODE_W-1:0] in_code_bits,
  input  logic [huf_pkg::LEN_W-1:0] in_code_length,
  input  logic                      in_bit_req,
  input  logic                      in_end_of_stream,
  input  logic                      q_ready,
  output logic                      q_push,
  output huf_pkg::op_t              q_op
);
  import huf_pkg::*;

  localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic [LEN_W-1:0] eff_len;

  // The effective length is bounded by the longest code and by the code word.
  assign eff_len = (in_code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : in_code_length;

  // Handshake: an item goes straight into the queue when it has room.
  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // Build the queue entry; a load code is shifted so its first bit sits on top, other codes are zero.
  always_comb begin
    q_op.func    = in_func;
    q_op.symbol  = in_symbol;
    q_op.eff_len = eff_len;
    q_op.bit_req = in_bit_req;
    q_op.eos     = in_end_of_stream;
    if (in_func == FUNC_LOAD) begin
      q_op.code = in_code_bits << (LEN_W'(CODE_W) - eff_len);
    end else begin
      q_op.code = '0;
    end
  end

endmodule

// ===== rtl/huf_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on huf_pkg for the entry type and depth.
module huf_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  huf_pkg::op_t push_op,
  output logic         push_ready,
  input  logic         pop,
  output logic         pop_valid,
  output huf_pkg::op_t pop_op
);
  import huf_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t           entry_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && push_ready) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop && pop_valid) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if ((push && push_ready) && !(pop && pop_valid)) begin
      count_nxt = count_r + 1'b1;
    end else if (!(push && push_ready) && (pop && pop_valid)) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/huf_back.sv =====
// Back part of the code-tree decoder: node store, operation sequencer, result register.
// Carries out clear, load and decode items taken from the queue. Depends on huf_pkg.
module huf_back #(
  parameter int MAX_NODES = huf_pkg::MAX_NODES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  huf_pkg::op_t              q_op,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [huf_pkg::SYM_W-1:0] out_decoded_symbol,
  output logic                      out_symbol_valid,
  output logic                      out_status
);
  import huf_pkg::*;

  localparam int NW   = $clog2(MAX_NODES);
  localparam int UW   = $clog2(MAX_NODES + 1);
  localparam int SUMW = $clog2(MAX_NODES + CODE_W + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LWALK  = 3'd1;
  localparam logic [2:0] S_LCHK   = 3'd2;
  localparam logic [2:0] S_LALLOC = 3'd3;
  localparam logic [2:0] S_DCUR   = 3'd4;
  localparam logic [2:0] S_DNEXT  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Node store: one array per field, one write and one registered read a cycle.
  logic [NW-1:0]    left_mem  [MAX_NODES];
  logic [NW-1:0]    right_mem [MAX_NODES];
  logic [SYM_W-1:0] sym_mem   [MAX_NODES];

  logic [NW-1:0]    rd_addr;
  logic [NW-1:0]    rd_left_r, rd_right_r;
  logic [SYM_W-1:0] rd_sym_r;
  logic [NW-1:0]    wr_addr;
  logic             we_left, we_right, we_sym;
  logic [NW-1:0]    wd_left, wd_right;
  logic [SYM_W-1:0] wd_sym;

  // Sequencer and tree state.
  logic [2:0]        state_r, state_nxt;
  logic [NW-1:0]     node_r, node_nxt;
  logic [LEN_W-1:0]  depth_r, depth_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  eff_r, eff_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              bit_r, bit_nxt;
  logic              eos_r, eos_nxt;
  logic [NW-1:0]     walk_r, walk_nxt;
  logic [UW-1:0]     used_r, used_nxt;

  // Pending result and output register.
  logic [SYM_W-1:0] res_sym_r, res_sym_nxt;
  logic             res_valid_r, res_valid_nxt;
  logic             res_status_r, res_status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic             out_sv_r, out_sv_nxt;
  logic             out_st_r, out_st_nxt;

  // Helpers derived from the read data.
  logic             rd_leaf;
  logic [NW-1:0]    load_next;
  logic [NW-1:0]    dec_next;
  logic [LEN_W-1:0] needed;
  logic [SUMW-1:0]  need_total;
  logic             last_alloc;
  logic [NW-1:0]    fresh_plus;

  assign rd_leaf    = (rd_left_r == '0) || (rd_right_r == '0);
  assign load_next  = code_r[CODE_W-1] ? rd_right_r : rd_left_r;
  assign dec_next   = bit_r ? rd_right_r : rd_left_r;
  assign needed     = eff_r - depth_r;
  assign need_total = SUMW'(used_r) + SUMW'(needed);
  assign last_alloc = ((depth_r + 1'b1) == eff_r);
  assign fresh_plus = NW'(used_r + 1'b1);

  assign q_pop              = (state_r == S_IDLE) && q_valid;
  assign out_valid          = out_valid_r;
  assign out_decoded_symbol = out_sym_r;
  assign out_symbol_valid   = out_sv_r;
  assign out_status         = out_st_r;

  // Sequencer: one operation at a time, read address and writes per state.
  always_comb begin
    state_nxt      = state_r;
    node_nxt       = node_r;
    depth_nxt      = depth_r;
    code_nxt       = code_r;
    eff_nxt        = eff_r;
    sym_nxt        = sym_r;
    bit_nxt        = bit_r;
    eos_nxt        = eos_r;
    walk_nxt       = walk_r;
    used_nxt       = used_r;
    res_sym_nxt    = res_sym_r;
    res_valid_nxt  = res_valid_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_sym_nxt    = out_sym_r;
    out_sv_nxt     = out_sv_r;
    out_st_nxt     = out_st_r;
    rd_addr        = node_r;
    wr_addr        = node_r;
    we_left        = 1'b0;
    we_right       = 1'b0;
    we_sym         = 1'b0;
    wd_left        = '0;
    wd_right       = '0;
    wd_sym         = '0;

    // The output register empties when its item is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          sym_nxt        = q_op.symbol;
          code_nxt       = q_op.code;
          eff_nxt        = q_op.eff_len;
          bit_nxt        = q_op.bit_req;
          eos_nxt        = q_op.eos;
          depth_nxt      = '0;
          res_sym_nxt    = '0;
          res_valid_nxt  = 1'b0;
          res_status_nxt = 1'b0;
          case (q_op.func)
            FUNC_CLEAR: begin
              // Bare root: links and symbol cleared.
              wr_addr   = '0;
              we_left   = 1'b1;
              we_right  = 1'b1;
              we_sym    = 1'b1;
              used_nxt  = UW'(1);
              walk_nxt  = '0;
              state_nxt = S_DONE;
            end
            FUNC_LOAD: begin
              node_nxt  = '0;
              rd_addr   = '0;
              state_nxt = S_LWALK;
            end
            FUNC_DECODE: begin
              if (UW'(walk_r) >= used_r) begin
                node_nxt = '0;
                rd_addr  = '0;
              end else begin
                node_nxt = walk_r;
                rd_addr  = walk_r;
              end
              state_nxt = S_DCUR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Follow the existing path one node a cycle.
      S_LWALK: begin
        if ((depth_r == eff_r) || (load_next == '0)) begin
          state_nxt = S_LCHK;
        end else begin
          node_nxt  = load_next;
          rd_addr   = load_next;
          depth_nxt = depth_r + 1'b1;
          code_nxt  = code_r << 1;
        end
      end

      // Room check, then an error status when the store is full, else the symbol write or the first new link.
      S_LCHK: begin
        if (need_total > SUMW'(MAX_NODES)) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_DONE;
        end else if (needed == '0) begin
          wr_addr   = node_r;
          we_sym    = 1'b1;
          wd_sym    = sym_r;
          state_nxt = S_DONE;
        end else begin
          wr_addr = node_r;
          if (code_r[CODE_W-1]) begin
            we_right = 1'b1;
            wd_right = NW'(used_r);
          end else begin
            we_left = 1'b1;
            wd_left = NW'(used_r);
          end
          state_nxt = S_LALLOC;
        end
      end

      // Write one fresh node a cycle, linked to the next fresh node or, if last, holding the symbol.
      S_LALLOC: begin
        wr_addr  = NW'(used_r);
        we_left  = 1'b1;
        we_right = 1'b1;
        we_sym   = 1'b1;
        if (last_alloc) begin
          wd_sym    = sym_r;
          state_nxt = S_DONE;
        end else if (code_r[CODE_W-2]) begin
          wd_right = fresh_plus;
        end else begin
          wd_left = fresh_plus;
        end
        used_nxt  = used_r + 1'b1;
        depth_nxt = depth_r + 1'b1;
        code_nxt  = code_r << 1;
      end

      // Current node: a node lacking a child emits without moving.
      S_DCUR: begin
        if (rd_leaf) begin
          res_sym_nxt   = rd_sym_r;
          res_valid_nxt = 1'b1;
          walk_nxt      = '0;
          state_nxt     = S_DONE;
        end else begin
          node_nxt  = dec_next;
          rd_addr   = dec_next;
          walk_nxt  = eos_r ? '0 : dec_next;
          state_nxt = S_DNEXT;
        end
      end

      // Child node: emit if it lacks a child, else stay there.
      S_DNEXT: begin
        if (rd_leaf) begin
          res_sym_nxt   = rd_sym_r;
          res_valid_nxt = 1'b1;
          walk_nxt      = '0;
        end
        state_nxt = S_DONE;
      end

      // Hand the result over once the output register is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = res_sym_r;
          out_sv_nxt    = res_valid_r;
          out_st_nxt    = res_status_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_r      <= '0;
      used_r      <= UW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    node_r       <= node_nxt;
    depth_r      <= depth_nxt;
    code_r       <= code_nxt;
    eff_r        <= eff_nxt;
    sym_r        <= sym_nxt;
    bit_r        <= bit_nxt;
    eos_r        <= eos_nxt;
    res_sym_r    <= res_sym_nxt;
    res_valid_r  <= res_valid_nxt;
    res_status_r <= res_status_nxt;
    out_sym_r    <= out_sym_nxt;
    out_sv_r     <= out_sv_nxt;
    out_st_r     <= out_st_nxt;
  end

  // Node store write port.
  always_ff @(posedge clk) begin
    if (we_left) begin
      left_mem[wr_addr] <= wd_left;
    end
    if (we_right) begin
      right_mem[wr_addr] <= wd_right;
    end
    if (we_sym) begin
      sym_mem[wr_addr] <= wd_sym;
    end
  end

  // Node store read port with registered data.
  always_ff @(posedge clk) begin
    rd_left_r  <= left_mem[rd_addr];
    rd_right_r <= right_mem[rd_addr];
    rd_sym_r   <= sym_mem[rd_addr];
  end

  // The root entry is written by the startup clear that the top level issues after reset.
endmodule

// ===== rtl/huffman_tree_decoder.sv =====
// Top level of the code-tree decoder: front, queue and back joined together.
// Depends on huf_pkg, huf_front, huf_queue and huf_back.
//
//   Channel  Ports                                                Handshake
//   input    in_func in_symbol in_code_bits in_code_length        in_valid / in_ready
//            in_bit_req in_end_of_stream
//   result   out_decoded_symbol out_symbol_valid out_status       out_valid / out_ready
//
// Each item gives one result. Clear and an unknown func go straight to the result; decode
// makes one dependent node-store read per tree level visited, and load first follows the d
// existing links and then allocates the n new nodes that the code still needs.
// The node store has a single read and write port.
// After reset the block runs a root clear before it takes the first item.
// A two-entry queue keeps the input side moving while the back works or the result stalls.
module huffman_tree_decoder #(
  parameter int MAX_NODES    = huf_pkg::MAX_NODES_DEF,
  parameter int MAX_CODE_LEN = huf_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_func,
  input  logic [huf_pkg::SYM_W-1:0]  in_symbol,
  input  logic [huf_pkg::CODE_W-1:0] in_code_bits,
  input  logic [huf_pkg::LEN_W-1:0]  in_code_length,
  input  logic                       in_bit_req,
  input  logic                       in_end_of_stream,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [huf_pkg::SYM_W-1:0]  out_decoded_symbol,
  output logic                       out_symbol_valid,
  output logic                       out_status
);
  import huf_pkg::*;

  logic init_done_r;
  logic fe_ready, fe_push, q_push_ready;
  op_t  fe_op, q_op, back_op;
  logic q_valid, q_pop, back_valid;

  // Right after reset a synthetic clear item writes the root entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r <= 1'b0;
    end else if (!init_done_r && q_pop) begin
      init_done_r <= 1'b1;
    end
  end

  huf_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (fe_ready),
    .in_func         (in_func),
    .in_symbol       (in_symbol),
    .in_code_bits    (in_code_bits),
    .in_code_length  (in_code_length),
    .in_bit_req      (in_bit_req),
    .in_end_of_stream(in_end_of_stream),
    .q_ready         (q_push_ready),
    .q_push          (fe_push),
    .q_op            (fe_op)
  );

  assign in_ready = fe_ready;

  huf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_push),
    .push_op   (fe_op),
    .push_ready(q_push_ready),
    .pop       (q_pop && init_done_r),
    .pop_valid (q_valid),
    .pop_op    (q_op)
  );

  // The startup clear goes to the back ahead of any queued item; its result is dropped.
  always_comb begin
    back_op = q_op;
    if (!init_done_r) begin
      back_op      = '0;
      back_op.func = FUNC_CLEAR;
    end
  end

  assign back_valid = init_done_r ? q_valid : 1'b1;

  logic             b_out_valid;
  logic             b_out_ready;
  logic [SYM_W-1:0] b_sym;
  logic             b_sv, b_st;
  logic             init_res_r;

  // Swallow the result of the startup clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_res_r <= 1'b1;
    end else if (init_res_r && b_out_valid) begin
      init_res_r <= 1'b0;
    end
  end

  assign b_out_ready        = init_res_r ? 1'b1 : out_ready;
  assign out_valid          = b_out_valid && !init_res_r;
  assign out_decoded_symbol = b_sym;
  assign out_symbol_valid   = b_sv;
  assign out_status         = b_st;

  huf_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (back_valid),
    .q_op              (back_op),
    .q_pop             (q_pop),
    .out_valid         (b_out_valid),
    .out_ready         (b_out_ready),
    .out_decoded_symbol(b_sym),
    .out_symbol_valid  (b_sv),
    .out_status        (b_st)
  );

endmodule
